FILE: hdl/aabb_affine_transform_assert.svh
// Assertion macros shared by the box transform RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AABB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/aabb_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the axis-aligned box affine transform.
// No dependencies; imported by every module of the block.
package aabb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 16;
  // Fraction bits of a Q4.12 coefficient; each product is shifted by this.
  localparam int COEF_FRAC       = 12;
  localparam int NUM_AXES        = 3;
  localparam int CFG_IDX_WIDTH   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_X = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_Y = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_Z = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_OFS_X = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_OFS_Y = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_OFS_Z = 3'd5;

endpackage

FILE: hdl/aabb_mul.sv
`timescale 1ns / 1ps
// Multiply stage: all eighteen coefficient-by-corner products, floor-shifted.
// Depends on aabb_pkg.
module aabb_mul
  import aabb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  localparam int TW = COORD_WIDTH + COEF_WIDTH - COEF_FRAC
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3*COEF_WIDTH-1:0]       row_coef [NUM_AXES],
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [COORD_WIDTH-1:0] lo [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] hi [NUM_AXES],
  input  logic                          ok,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [TW-1:0]          t_lo [NUM_AXES][NUM_AXES],
  output logic signed [TW-1:0]          t_hi [NUM_AXES][NUM_AXES],
  output logic                          dn_ok
);

  localparam int PW = COORD_WIDTH + COEF_WIDTH;

  logic                 valid_r;
  logic                 ok_r;
  logic signed [TW-1:0] t_lo_r [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_hi_r [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_lo_nxt [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_hi_nxt [NUM_AXES][NUM_AXES];
  logic                 load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // Row r, column c: coefficient times input axis c, shifted toward minus infinity.
  for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
    for (genvar c = 0; c < NUM_AXES; c++) begin : g_col
      logic signed [COEF_WIDTH-1:0] k;
      logic signed [PW-1:0]         p_lo;
      logic signed [PW-1:0]         p_hi;
      assign k    = $signed(row_coef[r][c*COEF_WIDTH +: COEF_WIDTH]);
      assign p_lo = PW'(k) * PW'(lo[c]);
      assign p_hi = PW'(k) * PW'(hi[c]);
      assign t_lo_nxt[r][c] = TW'(p_lo >>> COEF_FRAC);
      assign t_hi_nxt[r][c] = TW'(p_hi >>> COEF_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= ok;
      t_lo_r <= t_lo_nxt;
      t_hi_r <= t_hi_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ok    = ok_r;
  assign t_lo     = t_lo_r;
  assign t_hi     = t_hi_r;

endmodule

FILE: hdl/aabb_sel.sv
`timescale 1ns / 1ps
// Select stage: per term, the smaller and the larger of the two corner products.
// Depends on aabb_pkg.
module aabb_sel
  import aabb_pkg::*;
#(
  parameter int TW = COORD_WIDTH_DEF + COEF_WIDTH_DEF - COEF_FRAC
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [TW-1:0] t_lo [NUM_AXES][NUM_AXES],
  input  logic signed [TW-1:0] t_hi [NUM_AXES][NUM_AXES],
  input  logic                 ok,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [TW-1:0] t_min [NUM_AXES][NUM_AXES],
  output logic signed [TW-1:0] t_max [NUM_AXES][NUM_AXES],
  output logic                 dn_ok
);

  logic                 valid_r;
  logic                 ok_r;
  logic signed [TW-1:0] t_min_r [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_max_r [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_min_nxt [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] t_max_nxt [NUM_AXES][NUM_AXES];
  logic                 load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        if (t_lo[r][c] < t_hi[r][c]) begin
          t_min_nxt[r][c] = t_lo[r][c];
          t_max_nxt[r][c] = t_hi[r][c];
        end else begin
          t_min_nxt[r][c] = t_hi[r][c];
          t_max_nxt[r][c] = t_lo[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r    <= ok;
      t_min_r <= t_min_nxt;
      t_max_r <= t_max_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ok    = ok_r;
  assign t_min    = t_min_r;
  assign t_max    = t_max_r;

endmodule

FILE: hdl/aabb_sum.sv
`timescale 1ns / 1ps
// Sum and saturate stages: offset plus three terms per axis, then clamp
// and empty-box substitution into the output register. Depends on aabb_pkg.
module aabb_sum
  import aabb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TW = COORD_WIDTH_DEF + COEF_WIDTH_DEF - COEF_FRAC
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [COORD_WIDTH-1:0] offset [NUM_AXES],
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [TW-1:0]          t_min [NUM_AXES][NUM_AXES],
  input  logic signed [TW-1:0]          t_max [NUM_AXES][NUM_AXES],
  input  logic                          ok,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [COORD_WIDTH-1:0] box_lo [NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] box_hi [NUM_AXES],
  output logic                          box_ok
);

  // Two guard bits cover the carry of four addends.
  localparam int SW = ((TW > COORD_WIDTH) ? TW : COORD_WIDTH) + 2;
  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = SW'(CMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(CMIN);

  // Sum stage.
  logic                 s_valid_r;
  logic                 s_ok_r;
  logic signed [SW-1:0] s_min_r [NUM_AXES];
  logic signed [SW-1:0] s_max_r [NUM_AXES];
  logic signed [SW-1:0] s_min_nxt [NUM_AXES];
  logic signed [SW-1:0] s_max_nxt [NUM_AXES];
  logic                 s_ready;
  // Output stage.
  logic                          o_valid_r;
  logic                          o_ok_r;
  logic signed [COORD_WIDTH-1:0] o_lo_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] o_hi_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] o_lo_nxt [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] o_hi_nxt [NUM_AXES];
  logic                          o_ready;

  assign o_ready  = !o_valid_r || dn_ready;
  assign s_ready  = !s_valid_r || o_ready;
  assign up_ready = s_ready;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      s_min_nxt[r] = SW'(offset[r]) + SW'(t_min[r][0]) + SW'(t_min[r][1])
                     + SW'(t_min[r][2]);
      s_max_nxt[r] = SW'(offset[r]) + SW'(t_max[r][0]) + SW'(t_max[r][1])
                     + SW'(t_max[r][2]);
    end
  end

  // An inverted input box turns into the empty box: lo at the top, hi at the bottom.
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      if (!s_ok_r) begin
        o_lo_nxt[r] = CMAX;
        o_hi_nxt[r] = CMIN;
      end else begin
        if (s_min_r[r] > SMAX) begin
          o_lo_nxt[r] = CMAX;
        end else if (s_min_r[r] < SMIN) begin
          o_lo_nxt[r] = CMIN;
        end else begin
          o_lo_nxt[r] = COORD_WIDTH'(s_min_r[r]);
        end
        if (s_max_r[r] > SMAX) begin
          o_hi_nxt[r] = CMAX;
        end else if (s_max_r[r] < SMIN) begin
          o_hi_nxt[r] = CMIN;
        end else begin
          o_hi_nxt[r] = COORD_WIDTH'(s_max_r[r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (s_ready) begin
        s_valid_r <= up_valid;
      end
      if (o_ready) begin
        o_valid_r <= s_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s_ready) begin
      s_ok_r  <= ok;
      s_min_r <= s_min_nxt;
      s_max_r <= s_max_nxt;
    end
    if (s_valid_r && o_ready) begin
      o_ok_r <= s_ok_r;
      o_lo_r <= o_lo_nxt;
      o_hi_r <= o_hi_nxt;
    end
  end

  assign dn_valid = o_valid_r;
  assign box_ok   = o_ok_r;
  assign box_lo   = o_lo_r;
  assign box_hi   = o_hi_r;

endmodule

FILE: hdl/aabb_affine_transform.sv
// Affine transform of an axis-aligned box; top level. Uses aabb_pkg, aabb_mul,
// aabb_sel, aabb_sum and the assertion macros in aabb_affine_transform_assert.svh.
// A result passes through five register stages (input, multiply, min/max select, sum,
// saturate) after its item is accepted. Throughput: one item per cycle; each stage holds
// its item only while the stage after it is full and stalled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity map.
`timescale 1ns / 1ps
`include "aabb_affine_transform_assert.svh"

module aabb_affine_transform
  import aabb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFG_DATA_W  = (3 * COEF_WIDTH > COORD_WIDTH) ? 3 * COEF_WIDTH : COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  // Input box stream.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_W-1:0]    in_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, zero pad
  // Result box stream.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata,  // out_lo_x, out_lo_y, out_lo_z,
                                               // out_hi_x, out_hi_y, out_hi_z, zero pad
  output logic                     out_tuser   // box_valid
);

  localparam int TW = COORD_WIDTH + COEF_WIDTH - COEF_FRAC;
  localparam int RW = 3 * COEF_WIDTH;

  // A coefficient of 1.0 in Q4.12; the reset map is the identity.
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC);
  localparam logic [RW-1:0] ROW_X_RST = RW'(COEF_ONE);
  localparam logic [RW-1:0] ROW_Y_RST = RW'(COEF_ONE) << COEF_WIDTH;
  localparam logic [RW-1:0] ROW_Z_RST = RW'(COEF_ONE) << (2 * COEF_WIDTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to indexes beyond the offsets are dropped.
  // ---------------------------------------------------------------------------
  logic [RW-1:0]                 row_coef_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] offset_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_coef_r[0] <= ROW_X_RST;
      row_coef_r[1] <= ROW_Y_RST;
      row_coef_r[2] <= ROW_Z_RST;
      offset_r[0]   <= '0;
      offset_r[1]   <= '0;
      offset_r[2]   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROW_X: row_coef_r[0] <= cfg_wdata[RW-1:0];
        CFG_ROW_Y: row_coef_r[1] <= cfg_wdata[RW-1:0];
        CFG_ROW_Z: row_coef_r[2] <= cfg_wdata[RW-1:0];
        CFG_OFS_X: offset_r[0]   <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        CFG_OFS_Y: offset_r[1]   <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        CFG_OFS_Z: offset_r[2]   <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the box and check that every axis has lo <= hi.
  // Every stage below follows the same rule: it takes a new item when it is
  // empty or when its own item moves on in the same cycle, so bubbles close up
  // and the input keeps flowing while a finished result waits at the output.
  // ---------------------------------------------------------------------------
  logic                          s1_valid_r;
  logic                          s1_ok_r;
  logic signed [COORD_WIDTH-1:0] s1_lo_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s1_hi_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] in_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] in_hi [NUM_AXES];
  logic                          in_ok;
  logic                          mul_ready;

  always_comb begin
    in_ok = 1'b1;
    for (int c = 0; c < NUM_AXES; c++) begin
      in_lo[c] = $signed(in_tdata[c*COORD_WIDTH +: COORD_WIDTH]);
      in_hi[c] = $signed(in_tdata[(c+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH]);
      if (in_lo[c] > in_hi[c]) begin
        in_ok = 1'b0;
      end
    end
  end

  assign in_tready = !s1_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ok_r <= in_ok;
      s1_lo_r <= in_lo;
      s1_hi_r <= in_hi;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products. Stage 3: per-term min/max. Stages 4 and 5: sums and clamp.
  // Every output term depends on one input axis only, so picking the smaller or
  // larger product per term gives the same box as mapping all eight corners.
  // ---------------------------------------------------------------------------
  logic                 mul_valid;
  logic                 mul_ok;
  logic signed [TW-1:0] mul_t_lo [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] mul_t_hi [NUM_AXES][NUM_AXES];
  logic                 sel_ready;
  logic                 sel_valid;
  logic                 sel_ok;
  logic signed [TW-1:0] sel_t_min [NUM_AXES][NUM_AXES];
  logic signed [TW-1:0] sel_t_max [NUM_AXES][NUM_AXES];
  logic                 sum_ready;

  aabb_mul #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .row_coef (row_coef_r),
    .up_valid (s1_valid_r),
    .up_ready (mul_ready),
    .lo       (s1_lo_r),
    .hi       (s1_hi_r),
    .ok       (s1_ok_r),
    .dn_valid (mul_valid),
    .dn_ready (sel_ready),
    .t_lo     (mul_t_lo),
    .t_hi     (mul_t_hi),
    .dn_ok    (mul_ok)
  );

  aabb_sel #(
    .TW (TW)
  ) u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (sel_ready),
    .t_lo     (mul_t_lo),
    .t_hi     (mul_t_hi),
    .ok       (mul_ok),
    .dn_valid (sel_valid),
    .dn_ready (sum_ready),
    .t_min    (sel_t_min),
    .t_max    (sel_t_max),
    .dn_ok    (sel_ok)
  );

  logic signed [COORD_WIDTH-1:0] box_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] box_hi [NUM_AXES];
  logic                          box_ok;

  aabb_sum #(
    .COORD_WIDTH (COORD_WIDTH),
    .TW          (TW)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .offset   (offset_r),
    .up_valid (sel_valid),
    .up_ready (sum_ready),
    .t_min    (sel_t_min),
    .t_max    (sel_t_max),
    .ok       (sel_ok),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .box_lo   (box_lo),
    .box_hi   (box_hi),
    .box_ok   (box_ok)
  );

  // Pack the result item; any padding above the six fields stays zero.
  always_comb begin
    out_tdata = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      out_tdata[r*COORD_WIDTH +: COORD_WIDTH]            = box_lo[r];
      out_tdata[(r+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH] = box_hi[r];
    end
  end
  assign out_tuser = box_ok;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // The input can only back up when the whole pipeline is full behind a stalled output.
  `AABB_ASSERT_NOW(a_stall_chain, !in_tready, out_tvalid && !out_tready,
                   "input stalled while the output is not stalled")
  // A valid result box is never inverted on any axis.
  `AABB_ASSERT_NOW(a_valid_ordered, out_tvalid && box_ok,
                   box_lo[0] <= box_hi[0] && box_lo[1] <= box_hi[1] &&
                   box_lo[2] <= box_hi[2],
                   "valid result box has lo above hi")
  // An invalid result is exactly the empty box.
  `AABB_ASSERT_NOW(a_empty_box, out_tvalid && !box_ok,
                   box_lo[0] == CMAX && box_lo[1] == CMAX && box_lo[2] == CMAX &&
                   box_hi[0] == CMIN && box_hi[1] == CMIN && box_hi[2] == CMIN,
                   "invalid result is not the empty box")
  // An offset write lands in its register on the next cycle.
  `AABB_ASSERT_NEXT(a_cfg_offset_x, cfg_we && cfg_addr == CFG_OFS_X,
                    offset_r[0] == $signed($past(cfg_wdata[COORD_WIDTH-1:0])),
                    "offset x write not taken")

endmodule
